>>> rtl/sobel_pkg.sv
// Shared constants, types and command/status bundles for the Sobel edge block.
package sobel_pkg;

  localparam int MAX_WIDTH = 256;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int FW_W      = 9;
  localparam int FH_W      = 12;
  localparam int ROW_W     = 12;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;
  localparam int PIX_W     = 16;
  localparam int GRAY_W    = 5;
  localparam int GRAY_LSB  = 11;
  localparam int GRAD_W    = 8;
  localparam int SQ_W      = 16;
  localparam int MAG_W     = 5;

  localparam logic [FW_W-1:0] FW_RESET = FW_W'(160);
  localparam logic [FH_W-1:0] FH_RESET = FH_W'(120);
  localparam logic [FW_W-1:0] FW_MIN   = FW_W'(3);
  localparam logic [FW_W-1:0] FW_MAX   = FW_W'(MAX_WIDTH);
  localparam logic [FH_W-1:0] FH_MIN   = FH_W'(3);

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  // Root unit works on the sum clipped just below 32*32, so the root never exceeds 31.
  localparam int ROOT_IN_W  = 2 * MAG_W;
  localparam int ROOT_STEPS = MAG_W;
  localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);
  localparam int ROOT_BIT_W = ROOT_IN_W - 1;
  localparam logic [ROOT_BIT_W-1:0] ROOT_BIT_INIT = ROOT_BIT_W'(1) << (ROOT_IN_W - 2);
  localparam logic [ROOT_IN_W-1:0]  ROOT_CLIP     = {ROOT_IN_W{1'b1}};

  typedef struct packed {
    logic accept;     // latch pixel, position, issue line-store read
    logic shift;      // advance window, write line stores, step counters
    logic grad;       // form gx and gy
    logic square;     // square, sum, clip, seed root unit
    logic root_step;  // one digit of the root
    logic emit;       // load output register
  } sobel_cmd_t;

  typedef struct packed {
    logic produce;    // current word yields a result
    logic out_free;   // output register can take a word this cycle
  } sobel_sts_t;

endpackage

>>> rtl/sobel_ctrl.sv
// Sequencer for the Sobel edge block: steps one word through the datapath.
module sobel_ctrl
  import sobel_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  sobel_sts_t sts_i,
  output sobel_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WIN  = 3'd1;
  localparam logic [2:0] ST_GRAD = 3'd2;
  localparam logic [2:0] ST_SQ   = 3'd3;
  localparam logic [2:0] ST_ROOT = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  localparam logic [ROOT_CNT_W-1:0] ROOT_LAST = ROOT_CNT_W'(ROOT_STEPS - 1);

  logic [2:0]            state_q, state_d;
  logic [ROOT_CNT_W-1:0] root_cnt_q, root_cnt_d;

  always_comb begin
    state_d    = state_q;
    root_cnt_d = root_cnt_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_WIN;
        end
      end
      ST_WIN: begin
        cmd_o.shift = 1'b1;
        state_d     = sts_i.produce ? ST_GRAD : ST_IDLE;
      end
      ST_GRAD: begin
        cmd_o.grad = 1'b1;
        state_d    = ST_SQ;
      end
      ST_SQ: begin
        cmd_o.square = 1'b1;
        root_cnt_d   = '0;
        state_d      = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        root_cnt_d      = root_cnt_q + 1'b1;
        if (root_cnt_q == ROOT_LAST) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hold until the output register frees up
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      root_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      root_cnt_q <= root_cnt_d;
    end
  end

  a_accept_then_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> state_q == ST_WIN)
    else $error("accepted word did not advance to window step");

  a_root_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROOT && root_cnt_q == ROOT_LAST) |=> state_q == ST_EMIT)
    else $error("root did not finish after its digit count");

  a_emit_after_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> ($past(state_q) == ST_ROOT || $past(state_q) == ST_EMIT))
    else $error("emit state entered without a root");

endmodule

>>> rtl/sobel_dp.sv
// Datapath of the Sobel edge block: config, counters, line stores, window, gradients, root, output.
module sobel_dp
  import sobel_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic [PIX_W-1:0]     pixel_in_i,
  input  sobel_cmd_t           cmd_i,
  output sobel_sts_t           sts_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [PIX_W-1:0]     edge_pixel_o,
  output logic [MAG_W-1:0]     magnitude_o,
  output logic                 last_of_frame_o
);

  // configuration
  logic [FW_W-1:0] fw_q;
  logic [FH_W-1:0] fh_q;
  logic [FW_W-1:0] w_eff;
  logic [FH_W-1:0] h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FW_RESET;
      fh_q <= FH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH:  fw_q <= cfg_wdata_i[FW_W-1:0];
        CFG_FRAME_HEIGHT: fh_q <= cfg_wdata_i[FH_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    priority if (fw_q < FW_MIN) begin
      w_eff = FW_MIN;
    end else if (fw_q > FW_MAX) begin
      w_eff = FW_MAX;
    end else begin
      w_eff = fw_q;
    end
    h_eff = (fh_q < FH_MIN) ? FH_MIN : fh_q;
  end

  // position of the incoming word, after a late size change is applied
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] c_acc, c_q;
  logic [ROW_W-1:0] r_pre, r_acc, r_q;
  logic             col_wrap;
  logic [FW_W-1:0]  c_next;
  logic [ROW_W-1:0] r_next;
  logic             produce_q, last_q;
  logic [GRAY_W-1:0] g_q;

  always_comb begin
    col_wrap = {1'b0, col_q} >= w_eff;
    c_acc    = col_wrap ? '0 : col_q;
    r_pre    = col_wrap ? row_q + 1'b1 : row_q;
    r_acc    = (r_pre >= h_eff) ? '0 : r_pre;

    c_next   = {1'b0, c_q} + 1'b1;
    r_next   = r_q + 1'b1;
    col_d    = col_q;
    row_d    = row_q;
    if (cmd_i.shift) begin
      if (c_next >= w_eff) begin
        col_d = '0;
        row_d = (r_next >= h_eff) ? '0 : r_next;
      end else begin
        col_d = c_next[COL_W-1:0];
        row_d = r_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      produce_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cmd_i.accept) begin
        produce_q <= (r_acc >= ROW_W'(2)) && (c_acc >= COL_W'(2));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      c_q    <= c_acc;
      r_q    <= r_acc;
      g_q    <= pixel_in_i[GRAY_LSB +: GRAY_W];
      last_q <= (r_acc == h_eff - 1'b1) && ({1'b0, c_acc} == w_eff - 1'b1);
    end
  end

  // line stores: read at accept, written back in the window step
  logic [GRAY_W-1:0]    older_mem [MAX_WIDTH];
  logic [GRAY_W-1:0]    newer_mem [MAX_WIDTH];
  logic [MAX_WIDTH-1:0] line_vld_q;
  logic [GRAY_W-1:0]    older_rd_q, newer_rd_q;
  logic                 rd_vld_q;
  logic [GRAY_W-1:0]    older_val, newer_val;

  assign older_val = rd_vld_q ? older_rd_q : '0;
  assign newer_val = rd_vld_q ? newer_rd_q : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      older_rd_q <= older_mem[c_acc];
      newer_rd_q <= newer_mem[c_acc];
    end
    if (cmd_i.shift) begin
      older_mem[c_q] <= newer_val;
      newer_mem[c_q] <= g_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_vld_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        rd_vld_q <= line_vld_q[c_acc];
      end
      if (cmd_i.shift) begin
        line_vld_q[c_q] <= 1'b1;
      end
    end
  end

  // 3x3 window, row major, top row first
  logic [GRAY_W-1:0] win_q [9];
  logic [GRAY_W-1:0] win_d [9];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      win_d[i] = win_q[i];
    end
    if (cmd_i.shift) begin
      for (int i = 0; i < 3; i++) begin
        win_d[i*3]     = win_q[i*3 + 1];
        win_d[i*3 + 1] = win_q[i*3 + 2];
      end
      win_d[2] = older_val;
      win_d[5] = newer_val;
      win_d[8] = g_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

  // gradients
  logic signed [GRAD_W-1:0] p [9];
  logic signed [GRAD_W-1:0] gx_q, gy_q;
  logic signed [SQ_W-1:0]   gx_ext, gy_ext;
  logic [SQ_W-1:0]          sq_sum;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      p[i] = $signed({{(GRAD_W-GRAY_W){1'b0}}, win_q[i]});
    end
    gx_ext = SQ_W'(gx_q);
    gy_ext = SQ_W'(gy_q);
    sq_sum = SQ_W'(gx_ext * gx_ext) + SQ_W'(gy_ext * gy_ext);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.grad) begin
      gy_q <= p[6] + (p[7] <<< 1) + p[8] - p[0] - (p[1] <<< 1) - p[2];
      gx_q <= p[2] + (p[5] <<< 1) + p[8] - p[0] - (p[3] <<< 1) - p[6];
    end
  end

  // digit-by-digit root, one result bit a step
  logic [ROOT_IN_W-1:0]  rem_q;
  logic [ROOT_IN_W-1:0]  res_q;
  logic [ROOT_BIT_W-1:0] bit_q;
  logic [ROOT_IN_W:0]    trial;

  assign trial = {1'b0, res_q} + (ROOT_IN_W+1)'(bit_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.square) begin
      rem_q <= (sq_sum > SQ_W'(ROOT_CLIP)) ? ROOT_CLIP : sq_sum[ROOT_IN_W-1:0];
      res_q <= '0;
      bit_q <= ROOT_BIT_INIT;
    end else if (cmd_i.root_step) begin
      if ({1'b0, rem_q} >= trial) begin
        rem_q <= rem_q - trial[ROOT_IN_W-1:0];
        res_q <= (res_q >> 1) + ROOT_IN_W'(bit_q);
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // output register
  logic              out_valid_q;
  logic [MAG_W-1:0]  mag_q;
  logic              out_last_q;
  logic [MAG_W-1:0]  mag_res;

  assign mag_res = res_q[MAG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      mag_q      <= mag_res;
      out_last_q <= last_q;
    end
  end

  assign sts_o.produce   = produce_q;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign magnitude_o     = mag_q;
  assign edge_pixel_o    = {mag_q, mag_q, 1'b0, mag_q};
  assign last_of_frame_o = out_last_q;

  a_emit_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || !out_stall_i))
    else $error("output word overwritten while stalled");

  a_root_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (res_q >> MAG_W) == '0)
    else $error("root exceeds magnitude range");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q)
    else $error("emitted word not presented");

endmodule

>>> rtl/sobel_edge_magnitude_top.sv
// Top level of the streaming 3x3 Sobel edge magnitude block.
// The block takes RGB565 pixel words in raster order, keeps bits 15..11 as a gray
// level, and for every interior pixel of the frame returns one result word: the
// Sobel gradient magnitude m = min(31, floor(sqrt(gx^2 + gy^2))), on magnitude_o
// and packed as (m<<11)+(m<<6)+m on edge_pixel_o, with last_of_frame_o set on
// the bottom-right result. Border pixels give no result word. A word that yields
// a result steps through accept, window update, gradient, square and clip,
// five root digits from the one-digit-per-cycle root unit and output load; a
// border word steps through accept with line-store read and window update with
// line-store write. The output register lets the next pixel be accepted while a
// finished result still waits downstream. Frame width (3..256, 160 after reset)
// and height (3..4095, 120 after reset) are written through the cfg port; the
// user must do so only while the block is idle (the block does not enforce it);
// a size change takes effect on the next pixel. Line stores need no clearing
// pass: a valid bit per column makes unwritten entries read as zero.
module sobel_edge_magnitude_top
  import sobel_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // pixel words in
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [PIX_W-1:0]     pixel_in_i,
  // result words out
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [PIX_W-1:0]     edge_pixel_o,
  output logic [MAG_W-1:0]     magnitude_o,
  output logic                 last_of_frame_o
);

  sobel_cmd_t cmd;
  sobel_sts_t sts;

  // sequencer: decides which datapath step runs each cycle
  sobel_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: counters, line stores, window, gradients, root, output register
  sobel_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .pixel_in_i      (pixel_in_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .edge_pixel_o    (edge_pixel_o),
    .magnitude_o     (magnitude_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule
